// File: hw/rtl/adrl_pkg.sv
// ----------------------------------------------------------------------------
// adrl_pkg
// Shared types and constants for the alert de-duplication rate limiter.
// ----------------------------------------------------------------------------
package adrl_pkg;

	localparam int TABLE_DEPTH_DEF    = 32;
	localparam int VIOLATION_BITS_DEF = 8;

	localparam int TIME_W  = 32;
	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int VIOL_W  = 8;
	localparam int SEV_W   = 2;
	localparam int KIND_W  = 3;
	localparam int COUNT_W = 16;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_SUPPRESSED = 3'd0,
		KIND_NEW        = 3'd1,
		KIND_INTERVAL   = 3'd2,
		KIND_STALE      = 3'd3,
		KIND_UNTRACKED  = 3'd4
	} kind_t;

	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STALE    = 1'd1;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic [IP_W-1:0]   server_ip;
		logic [PORT_W-1:0] server_port;
		logic [VIOL_W-1:0] violation_id;
		logic [SEV_W-1:0]  severity;
	} alert_in_t;

	typedef struct packed {
		kind_t              kind;
		logic [IP_W-1:0]    out_ip;
		logic [PORT_W-1:0]  out_port;
		logic [VIOL_W-1:0]  out_violation;
		logic [SEV_W-1:0]   out_severity;
		logic [COUNT_W-1:0] alert_count;
		logic [TIME_W-1:0]  period_ms;
		logic               last;
	} alert_out_t;

endpackage

// File: hw/rtl/adrl_if.sv
// ----------------------------------------------------------------------------
// adrl_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface adrl_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/adrl_front.sv
// ----------------------------------------------------------------------------
// adrl_front
// Accepts alerts, masks the violation code and queues them for the engine.
// ----------------------------------------------------------------------------
module adrl_front #(
	parameter int VIOLATION_BITS = adrl_pkg::VIOLATION_BITS_DEF,
	parameter int QDEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	adrl_if.sink   alert_in,
	adrl_if.source to_engine
);
	import adrl_pkg::*;

	localparam int QA_W = $clog2(QDEPTH);

	alert_in_t          fifo_q [QDEPTH];
	logic [QA_W-1:0]    wr_q, rd_q;
	logic [QA_W:0]      cnt_q;
	alert_in_t          masked;
	logic               push, pop;

	always_comb begin
		masked = alert_in.payload;
		masked.violation_id = alert_in.payload.violation_id &
			VIOL_W'((1 << VIOLATION_BITS) - 1);
	end

	assign alert_in.ready   = (cnt_q != (QA_W+1)'(QDEPTH));
	assign push             = alert_in.valid && alert_in.ready;
	assign to_engine.valid  = (cnt_q != '0);
	assign to_engine.payload = fifo_q[rd_q];
	assign pop              = to_engine.valid && to_engine.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= masked;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QA_W'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QA_W'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QA_W+1)'(push) - (QA_W+1)'(pop);
		end
	end

endmodule

// File: hw/rtl/adrl_engine.sv
// ----------------------------------------------------------------------------
// adrl_engine
// Table sequencer: lookup, stale sweep with compaction, insert, reporting.
// ----------------------------------------------------------------------------
module adrl_engine #(
	parameter int TABLE_DEPTH = adrl_pkg::TABLE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [adrl_pkg::TIME_W-1:0] interval_ms,
	input  logic [adrl_pkg::TIME_W-1:0] stale_ms,
	adrl_if.sink   from_front,
	adrl_if.source result
);
	import adrl_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W = IP_W + PORT_W + VIOL_W + SEV_W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOOK, ST_LOOK_CHK, ST_SWEEP, ST_SWEEP_CHK, ST_MOVE, ST_MOVE_W,
		ST_OUT
	} state_t;

	// table memory, one port read, one write
	logic [KEY_W-1:0]   key_mem [TABLE_DEPTH];
	logic [TIME_W-1:0]  last_mem [TABLE_DEPTH];
	logic [COUNT_W-1:0] pend_mem [TABLE_DEPTH];

	state_t             state_q, after_out_q;
	logic [CNT_W-1:0]   used_q;
	logic [CNT_W-1:0]   i_q, j_q;
	alert_in_t          item_q;
	logic [IDX_W-1:0]   rd_addr;
	logic [KEY_W-1:0]   rd_key_q;
	logic [TIME_W-1:0]  rd_last_q;
	logic [COUNT_W-1:0] rd_pend_q;
	logic               we;
	logic [IDX_W-1:0]   wr_addr;
	logic [KEY_W-1:0]   wr_key;
	logic [TIME_W-1:0]  wr_last;
	logic [COUNT_W-1:0] wr_pend;
	alert_out_t         res_q;
	logic               res_v_q;
	logic               res_free;

	logic [KEY_W-1:0]   in_key;
	logic [TIME_W-1:0]  elapsed;
	logic [COUNT_W-1:0] pend_inc;

	assign in_key = {item_q.server_ip, item_q.server_port, item_q.violation_id,
		item_q.severity};
	assign elapsed  = item_q.now_ms - rd_last_q;
	assign pend_inc = (rd_pend_q == COUNT_MAX) ? rd_pend_q : rd_pend_q + 1'b1;

	assign from_front.ready = (state_q == ST_IDLE);
	assign result.valid     = res_v_q;
	assign result.payload   = res_q;

	// the result register is free for the next check stage
	assign res_free = !res_v_q || result.ready;

	// read address: i for lookup/sweep, j+1 while compacting
	always_comb begin
		case (state_q)
			ST_MOVE: rd_addr = IDX_W'(j_q + 1'b1);
			default: rd_addr = IDX_W'(i_q);
		endcase
	end

	always_ff @(posedge clk) begin
		rd_key_q  <= key_mem[rd_addr];
		rd_last_q <= last_mem[rd_addr];
		rd_pend_q <= pend_mem[rd_addr];
		if (we) begin
			key_mem[wr_addr]  <= wr_key;
			last_mem[wr_addr] <= wr_last;
			pend_mem[wr_addr] <= wr_pend;
		end
	end

	always_comb begin
		we = 1'b0;
		wr_addr = IDX_W'(i_q);
		wr_key = in_key;
		wr_last = item_q.now_ms;
		wr_pend = '0;
		case (state_q)
			ST_LOOK_CHK: begin
				if (rd_key_q == in_key) begin
					we = 1'b1;
					wr_last = (elapsed > interval_ms) ? item_q.now_ms : rd_last_q;
					wr_pend = (elapsed > interval_ms) ? '0 : pend_inc;
				end
			end
			ST_MOVE_W: begin
				we = 1'b1;
				wr_addr = IDX_W'(j_q);
				wr_key = rd_key_q;
				wr_last = rd_last_q;
				wr_pend = rd_pend_q;
			end
			ST_SWEEP_CHK: begin
				// insert once sweep is done and there is room
				if (i_q >= used_q && used_q != CNT_W'(TABLE_DEPTH)) begin
					we = 1'b1;
					wr_addr = IDX_W'(used_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			after_out_q <= ST_IDLE;
			used_q  <= '0;
			i_q     <= '0;
			j_q     <= '0;
			res_v_q <= 1'b0;
			res_q   <= '0;
			item_q  <= '0;
		end else begin
			if (result.valid && result.ready) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (from_front.valid) begin
						item_q  <= from_front.payload;
						i_q     <= '0;
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					// hold until a waiting result has left
					if (res_free) begin
						if (i_q < used_q) begin
							state_q <= ST_LOOK_CHK;
						end else begin
							i_q     <= '0;
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_LOOK_CHK: begin
					if (rd_key_q == in_key) begin
						res_q.kind <= (elapsed > interval_ms) ? KIND_INTERVAL
							: KIND_SUPPRESSED;
						{res_q.out_ip, res_q.out_port, res_q.out_violation,
							res_q.out_severity} <= in_key;
						res_q.alert_count <= pend_inc;
						res_q.period_ms   <= elapsed;
						res_q.last        <= 1'b1;
						after_out_q <= ST_IDLE;
						state_q     <= ST_OUT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_LOOK;
					end
				end
				ST_SWEEP: begin
					if (res_free) begin
						state_q <= ST_SWEEP_CHK;
					end
				end
				ST_SWEEP_CHK: begin
					if (i_q >= used_q) begin
						{res_q.out_ip, res_q.out_port, res_q.out_violation,
							res_q.out_severity} <= in_key;
						res_q.alert_count <= COUNT_W'(1);
						res_q.period_ms   <= '0;
						res_q.last        <= 1'b1;
						if (used_q == CNT_W'(TABLE_DEPTH)) begin
							res_q.kind <= KIND_UNTRACKED;
						end else begin
							res_q.kind <= KIND_NEW;
							used_q <= used_q + 1'b1;
						end
						after_out_q <= ST_IDLE;
						state_q     <= ST_OUT;
					end else if (elapsed > stale_ms) begin
						j_q <= i_q;
						if (rd_pend_q != '0) begin
							res_q.kind <= KIND_STALE;
							{res_q.out_ip, res_q.out_port, res_q.out_violation,
								res_q.out_severity} <= rd_key_q;
							res_q.alert_count <= rd_pend_q;
							res_q.period_ms   <= elapsed;
							res_q.last        <= 1'b0;
							after_out_q <= ST_MOVE;
							state_q     <= ST_OUT;
						end else begin
							state_q <= ST_MOVE;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_SWEEP;
					end
				end
				ST_MOVE: begin
					if (j_q + 1'b1 < used_q) begin
						state_q <= ST_MOVE_W;
					end else begin
						used_q  <= used_q - 1'b1;
						state_q <= ST_SWEEP;
					end
				end
				ST_MOVE_W: begin
					j_q     <= j_q + 1'b1;
					state_q <= ST_MOVE;
				end
				ST_OUT: begin
					if (!res_v_q) begin
						res_v_q <= 1'b1;
						state_q <= after_out_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/alert_dedup_rate_limiter.sv
// ----------------------------------------------------------------------------
// alert_dedup_rate_limiter
// Alert de-duplication and rate limiting over a table of tracked keys.
// ----------------------------------------------------------------------------
//  channel    dir  handshake     payload
//  alert_in   in   valid/ready   now_ms, key fields
//  alert_out  out  valid/ready   kind, key, count, period, last
//  cfg        in   cfg_we        cfg_index, cfg_data
//
// a hit scans table entries in order until its key matches; a miss ends the
// lookup, sweeps every entry, moves the later entries down for each removal
// and then emits its result, all paced by the single table memory read
// port. a two-deep queue lets alerts arrive while the engine works. reset
// empties the table at once; results wait in one output register and a
// stalled output holds the engine.
module alert_dedup_rate_limiter #(
	parameter int TABLE_DEPTH    = adrl_pkg::TABLE_DEPTH_DEF,
	parameter int VIOLATION_BITS = adrl_pkg::VIOLATION_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	adrl_if.sink   alert_in,
	adrl_if.source alert_out,
	input  logic cfg_we,
	input  logic [adrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [adrl_pkg::CFG_W-1:0]     cfg_data
);
	import adrl_pkg::*;

	logic [TIME_W-1:0] interval_q, stale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= TIME_W'(1000);
			stale_q    <= TIME_W'(10000);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INTERVAL: interval_q <= cfg_data;
				REG_STALE:    stale_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	adrl_if #(.payload_t(alert_in_t)) q_if ();

	adrl_front #(.VIOLATION_BITS(VIOLATION_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .alert_in(alert_in), .to_engine(q_if.source)
	);

	adrl_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
		.clk(clk), .arst_n(arst_n), .interval_ms(interval_q), .stale_ms(stale_q),
		.from_front(q_if.sink), .result(alert_out)
	);

endmodule
